// ----- hdl/row_range_directory_page_macros.svh -----
// row_range_directory_page_macros.svh: assertion macros for the row range directory rtl
// expects clk and rst_n in the scope of the module that uses them
`ifndef ROW_RANGE_DIRECTORY_PAGE_MACROS_SVH
`define ROW_RANGE_DIRECTORY_PAGE_MACROS_SVH

// same-cycle implication, off while in reset
`define RRDP_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, off while in reset
`define RRDP_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hdl/rrdp_pkg.sv -----
// rrdp_pkg: types, codes and constants of the row range directory page
// no dependencies; used by row_range_directory_page
package rrdp_pkg;

  localparam int unsigned RRDP_PAGE_ENTRIES = 32;
  localparam int unsigned RRDP_GROUPS       = 4;

  localparam int unsigned VAL_W     = 63;
  localparam int unsigned CFG_W     = 63;
  localparam int unsigned CFG_IDX_W = 2;

  localparam logic [VAL_W-1:0] MAX_ROW = '1;

  typedef enum logic [1:0] {
    MODE_INSERT = 2'd0,
    MODE_LOOKUP = 2'd1,
    MODE_FLUSH  = 2'd2
  } mode_t;

  typedef enum logic [1:0] {
    KIND_INSERT = 2'd0,
    KIND_LOOKUP = 2'd1,
    KIND_FLUSH  = 2'd2
  } kind_t;

  // status codes, per result kind
  localparam logic [1:0] INS_APPENDED = 2'd0;
  localparam logic [1:0] INS_SKIPPED  = 2'd1;
  localparam logic [1:0] INS_ZERO_CNT = 2'd2;
  localparam logic [1:0] LKP_HIT      = 2'd0;
  localparam logic [1:0] LKP_PAST_EOF = 2'd1;
  localparam logic [1:0] LKP_STALE    = 2'd2;
  localparam logic [1:0] LKP_MISS     = 2'd3;
  localparam logic [1:0] FL_ENTRY     = 2'd0;
  localparam logic [1:0] FL_EMPTY     = 2'd1;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_RANGE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PAGE_SIZE   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_END_OF_FILE = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_CUR_SEGMENT = 2'd3;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DECODE,
    ST_PREV_CHK,
    ST_PREV_FIX,
    ST_APPEND_CHK,
    ST_APPEND,
    ST_EMIT_RD,
    ST_EMIT_OUT,
    ST_SRCH_RD,
    ST_SRCH_CMP,
    ST_HIT_END,
    ST_MISS_CMP,
    ST_MISS_END
  } state_t;

  typedef struct packed {
    logic [1:0]       mode;
    logic [1:0]       group;
    logic [6:0]       segment;
    logic [VAL_W-1:0] row_num;
    logic [VAL_W-1:0] first_row;
    logic [VAL_W-1:0] file_offset;
    logic [VAL_W-1:0] row_count;
  } in_t;

  typedef struct packed {
    logic [1:0]       kind;
    logic [1:0]       status;
    logic [VAL_W-1:0] out_first_row;
    logic [VAL_W-1:0] out_offset;
    logic [VAL_W-1:0] after_offset;
    logic [VAL_W-1:0] last_row;
    logic [VAL_W-1:0] out_count;
    logic             last;
  } out_t;

endpackage

// ----- hdl/row_range_directory_page.sv -----
// row_range_directory_page: per-group directory page with insert, binary-search lookup, flush
// depends on rrdp_pkg, rrdp_ram and row_range_directory_page_macros.svh
//
//  port group  | dir | handshake          | payload
//  ------------+-----+--------------------+--------------------------
//  in_         | in  | in_valid/in_ready  | in_data  (rrdp_pkg::in_t)
//  out_        | out | out_valid/out_ready| out_data (rrdp_pkg::out_t)
//  cfg_        | in  | cfg_we             | cfg_index, cfg_data
//
// one item at a time; the three entry rams share one read address, one read per probe.
// insert: a full page is emitted entry by entry before the new entry is appended.
// lookup: a binary search of up to log2(PAGE_ENTRIES)+1 probes, and no search at all
// when the segment differs or the page is empty.
// flush: one result per entry. rst_n is synchronous; it empties every page at once
// (fill counts only, no ram clearing pass). a result waiting in the output register
// stalls only the next result transfer, not the item handshake in idle.
`include "row_range_directory_page_macros.svh"

module row_range_directory_page #(
  parameter int unsigned PAGE_ENTRIES = rrdp_pkg::RRDP_PAGE_ENTRIES,
  parameter int unsigned GROUPS       = rrdp_pkg::RRDP_GROUPS
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  rrdp_pkg::in_t                       in_data,
  output logic                                out_valid,
  input  logic                                out_ready,
  output rrdp_pkg::out_t                      out_data,
  input  logic                                cfg_we,
  input  logic [rrdp_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [rrdp_pkg::CFG_W-1:0]          cfg_data
);

  localparam int unsigned IW    = $clog2(PAGE_ENTRIES);
  localparam int unsigned CW    = $clog2(PAGE_ENTRIES + 1);
  localparam int unsigned GW    = (GROUPS > 1) ? $clog2(GROUPS) : 1;
  localparam int unsigned AW    = GW + IW;
  localparam int unsigned DEPTH = 2 ** AW;
  localparam int unsigned VW    = rrdp_pkg::VAL_W;

  // group field reduced into range by repeated subtraction
  function automatic logic [GW-1:0] group_of(input logic [1:0] grp);
    logic [4:0] v;
    v = {3'b000, grp};
    for (int k = 0; k < 3; k++) begin
      if (v >= 5'(GROUPS)) begin
        v = v - 5'(GROUPS);
      end
    end
    return GW'(v);
  endfunction

  rrdp_pkg::state_t state_r, state_nxt;
  rrdp_pkg::in_t    item_r;
  logic [GW-1:0]    g_r;
  logic [GW-1:0]    g_in;
  logic [CW-1:0]    usedc_r, usedc_nxt;
  logic [CW-1:0]    lo_r, lo_nxt, hip_r, hip_nxt, mid_r, mid_nxt;
  logic [CW-1:0]    mid_c, lo_c, hip_c;
  logic [IW-1:0]    idx_r, idx_nxt;
  logic [63:0]      acc_r, acc_nxt;
  logic [VW-1:0]    hit_fr_r, hit_fr_nxt, hit_off_r, hit_off_nxt;
  logic             hit_final_r, hit_final_nxt;

  logic [CW-1:0]    used_r [GROUPS];
  logic             used_we;
  logic [CW-1:0]    used_wd;

  logic [31:0]      min_range_r;
  logic [5:0]       page_size_r;
  logic [VW-1:0]    eof_r;
  logic [6:0]       cur_seg_r;

  logic             out_valid_r, out_valid_nxt;
  rrdp_pkg::out_t   out_data_r;
  rrdp_pkg::out_t   res;
  logic             load_out;
  logic             slot_free;

  logic             rd_en, we_ent, we_cnt;
  logic [AW-1:0]    rd_addr, wr_addr;
  logic [VW-1:0]    cnt_wd;
  logic [VW-1:0]    rd_row, rd_off, rd_cnt;

  // shared adder: a + b + cin with carry out
  logic [63:0]      add_a, add_b;
  logic             add_cin;
  logic [64:0]      add_full;

  logic [6:0]       used7, ps7, lim7;
  logic             page_full;
  logic             emit_final;
  logic             probe_hit;
  logic             skip_c;
  logic [VW-1:0]    aft_raw;

  assign g_in      = group_of(in_data.group);
  assign in_ready  = (state_r == rrdp_pkg::ST_IDLE);
  assign slot_free = !out_valid_r || out_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign add_full = {1'b0, add_a} + {1'b0, add_b} + 65'(add_cin);

  // effective page size: zero acts as one, capped at the page capacity
  assign used7 = 7'(usedc_r);
  assign ps7   = {1'b0, page_size_r};
  assign lim7  = (ps7 == 7'd0) ? 7'd1 :
                 (ps7 > 7'(PAGE_ENTRIES)) ? 7'(PAGE_ENTRIES) : ps7;
  assign page_full = (used7 >= lim7);

  assign emit_final = (CW'(idx_r) == usedc_r - CW'(1));
  assign mid_c      = lo_r + ((hip_r - lo_r) >> 1);
  assign probe_hit  = (rd_row <= item_r.row_num) && (add_full[63:0] > {1'b0, item_r.row_num});
  assign lo_c       = (rd_row > item_r.row_num) ? lo_r : mid_r + CW'(1);
  assign hip_c      = (rd_row > item_r.row_num) ? mid_r : hip_r;
  assign aft_raw    = hit_final_r ? eof_r : rd_off;

  // offset step check: carry out means file_offset >= previous offset
  assign skip_c = (min_range_r != 32'd0) &&
                  (!add_full[64] ||
                   ((add_full[62:32] == '0) && (add_full[31:0] < min_range_r)));

  always_comb begin
    state_nxt     = state_r;
    usedc_nxt     = usedc_r;
    lo_nxt        = lo_r;
    hip_nxt       = hip_r;
    mid_nxt       = mid_r;
    idx_nxt       = idx_r;
    acc_nxt       = acc_r;
    hit_fr_nxt    = hit_fr_r;
    hit_off_nxt   = hit_off_r;
    hit_final_nxt = hit_final_r;
    rd_en         = 1'b0;
    rd_addr       = '0;
    wr_addr       = {g_r, IW'(usedc_r)};
    we_ent        = 1'b0;
    we_cnt        = 1'b0;
    cnt_wd        = item_r.row_count;
    used_we       = 1'b0;
    used_wd       = '0;
    load_out      = 1'b0;
    res           = '0;
    add_a         = '0;
    add_b         = '0;
    add_cin       = 1'b0;

    unique case (state_r)
      rrdp_pkg::ST_IDLE: begin
        if (in_valid) begin
          usedc_nxt = used_r[g_in];
          state_nxt = rrdp_pkg::ST_DECODE;
        end
      end

      rrdp_pkg::ST_DECODE: begin
        unique case (item_r.mode)
          rrdp_pkg::MODE_INSERT: begin
            if (item_r.row_count == '0) begin
              res.kind   = rrdp_pkg::KIND_INSERT;
              res.status = rrdp_pkg::INS_ZERO_CNT;
              res.last   = 1'b1;
              if (slot_free) begin
                load_out  = 1'b1;
                state_nxt = rrdp_pkg::ST_IDLE;
              end
            end else if (usedc_r != '0) begin
              rd_en     = 1'b1;
              rd_addr   = {g_r, IW'(usedc_r - CW'(1))};
              state_nxt = rrdp_pkg::ST_PREV_CHK;
            end else begin
              state_nxt = rrdp_pkg::ST_APPEND_CHK;
            end
          end
          rrdp_pkg::MODE_LOOKUP: begin
            if ((item_r.segment == cur_seg_r) && (usedc_r != '0)) begin
              lo_nxt    = '0;
              hip_nxt   = usedc_r;
              state_nxt = rrdp_pkg::ST_SRCH_RD;
            end else begin
              res.kind   = rrdp_pkg::KIND_LOOKUP;
              res.status = rrdp_pkg::LKP_MISS;
              res.last   = 1'b1;
              if (slot_free) begin
                load_out  = 1'b1;
                state_nxt = rrdp_pkg::ST_IDLE;
              end
            end
          end
          rrdp_pkg::MODE_FLUSH: begin
            if (usedc_r == '0) begin
              res.kind   = rrdp_pkg::KIND_FLUSH;
              res.status = rrdp_pkg::FL_EMPTY;
              res.last   = 1'b1;
              if (slot_free) begin
                load_out  = 1'b1;
                state_nxt = rrdp_pkg::ST_IDLE;
              end
            end else begin
              idx_nxt   = '0;
              state_nxt = rrdp_pkg::ST_EMIT_RD;
            end
          end
          default: begin
            state_nxt = rrdp_pkg::ST_IDLE;
          end
        endcase
      end

      rrdp_pkg::ST_PREV_CHK: begin
        add_a   = {1'b0, item_r.file_offset};
        add_b   = ~{1'b0, rd_off};
        add_cin = 1'b1;
        if (skip_c) begin
          res.kind   = rrdp_pkg::KIND_INSERT;
          res.status = rrdp_pkg::INS_SKIPPED;
          res.last   = 1'b1;
          if (slot_free) begin
            load_out  = 1'b1;
            state_nxt = rrdp_pkg::ST_IDLE;
          end
        end else begin
          state_nxt = rrdp_pkg::ST_PREV_FIX;
        end
      end

      rrdp_pkg::ST_PREV_FIX: begin
        // previous entry's count becomes the row step, modulo 2^63
        add_a     = {1'b0, item_r.first_row};
        add_b     = ~{1'b0, rd_row};
        add_cin   = 1'b1;
        wr_addr   = {g_r, IW'(usedc_r - CW'(1))};
        we_cnt    = 1'b1;
        cnt_wd    = add_full[VW-1:0];
        state_nxt = rrdp_pkg::ST_APPEND_CHK;
      end

      rrdp_pkg::ST_APPEND_CHK: begin
        if (page_full) begin
          idx_nxt   = '0;
          state_nxt = rrdp_pkg::ST_EMIT_RD;
        end else begin
          state_nxt = rrdp_pkg::ST_APPEND;
        end
      end

      rrdp_pkg::ST_APPEND: begin
        res.kind   = rrdp_pkg::KIND_INSERT;
        res.status = rrdp_pkg::INS_APPENDED;
        res.last   = 1'b1;
        if (slot_free) begin
          load_out  = 1'b1;
          we_ent    = 1'b1;
          we_cnt    = 1'b1;
          used_we   = 1'b1;
          used_wd   = usedc_r + CW'(1);
          state_nxt = rrdp_pkg::ST_IDLE;
        end
      end

      rrdp_pkg::ST_EMIT_RD: begin
        rd_en     = 1'b1;
        rd_addr   = {g_r, idx_r};
        state_nxt = rrdp_pkg::ST_EMIT_OUT;
      end

      rrdp_pkg::ST_EMIT_OUT: begin
        res.kind          = rrdp_pkg::KIND_FLUSH;
        res.status        = rrdp_pkg::FL_ENTRY;
        res.out_first_row = rd_row;
        res.out_offset    = rd_off;
        res.out_count     = rd_cnt;
        res.last          = (item_r.mode == rrdp_pkg::MODE_FLUSH) && emit_final;
        if (slot_free) begin
          load_out = 1'b1;
          if (emit_final) begin
            used_we   = 1'b1;
            used_wd   = '0;
            usedc_nxt = '0;
            state_nxt = (item_r.mode == rrdp_pkg::MODE_INSERT) ?
                        rrdp_pkg::ST_APPEND : rrdp_pkg::ST_IDLE;
          end else begin
            idx_nxt   = idx_r + IW'(1);
            state_nxt = rrdp_pkg::ST_EMIT_RD;
          end
        end
      end

      rrdp_pkg::ST_SRCH_RD: begin
        rd_en     = 1'b1;
        rd_addr   = {g_r, IW'(mid_c)};
        mid_nxt   = mid_c;
        state_nxt = rrdp_pkg::ST_SRCH_CMP;
      end

      rrdp_pkg::ST_SRCH_CMP: begin
        add_a = {1'b0, rd_row};
        add_b = {1'b0, rd_cnt};
        if (probe_hit) begin
          acc_nxt       = add_full[63:0];
          hit_fr_nxt    = rd_row;
          hit_off_nxt   = rd_off;
          hit_final_nxt = (mid_r == usedc_r - CW'(1));
          // fetch the following entry for its offset
          if (mid_r != usedc_r - CW'(1)) begin
            rd_en   = 1'b1;
            rd_addr = {g_r, IW'(mid_r + CW'(1))};
          end
          state_nxt = rrdp_pkg::ST_HIT_END;
        end else begin
          lo_nxt  = lo_c;
          hip_nxt = hip_c;
          if (lo_c < hip_c) begin
            state_nxt = rrdp_pkg::ST_SRCH_RD;
          end else begin
            rd_en     = 1'b1;
            rd_addr   = {g_r, IW'(usedc_r - CW'(1))};
            state_nxt = rrdp_pkg::ST_MISS_CMP;
          end
        end
      end

      rrdp_pkg::ST_HIT_END: begin
        add_a             = acc_r;
        add_b             = '1;
        res.kind          = rrdp_pkg::KIND_LOOKUP;
        res.out_first_row = hit_fr_r;
        res.out_offset    = hit_off_r;
        res.last          = 1'b1;
        if (hit_off_r > eof_r) begin
          res.status = rrdp_pkg::LKP_PAST_EOF;
        end else begin
          res.status       = rrdp_pkg::LKP_HIT;
          res.after_offset = (aft_raw > eof_r) ? eof_r : aft_raw;
          res.last_row     = (hit_final_r && (min_range_r != 32'd0)) ?
                             rrdp_pkg::MAX_ROW : add_full[VW-1:0];
        end
        if (slot_free) begin
          load_out  = 1'b1;
          state_nxt = rrdp_pkg::ST_IDLE;
        end
      end

      rrdp_pkg::ST_MISS_CMP: begin
        add_a     = {1'b0, rd_row};
        add_b     = {1'b0, rd_cnt};
        acc_nxt   = add_full[63:0];
        state_nxt = rrdp_pkg::ST_MISS_END;
      end

      rrdp_pkg::ST_MISS_END: begin
        // end of the last entry minus one; carry out means the sum was nonzero
        add_a    = acc_r;
        add_b    = '1;
        res.kind = rrdp_pkg::KIND_LOOKUP;
        res.last = 1'b1;
        res.status = (add_full[64] && ({1'b0, item_r.row_num} < add_full[63:0])) ?
                     rrdp_pkg::LKP_STALE : rrdp_pkg::LKP_MISS;
        if (slot_free) begin
          load_out  = 1'b1;
          state_nxt = rrdp_pkg::ST_IDLE;
        end
      end

      default: begin
        state_nxt = rrdp_pkg::ST_IDLE;
      end
    endcase
  end

  assign out_valid_nxt = load_out ? 1'b1 : (out_ready ? 1'b0 : out_valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= rrdp_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_r <= in_data;
      g_r    <= g_in;
    end
    if (load_out) begin
      out_data_r <= res;
    end
    usedc_r     <= usedc_nxt;
    lo_r        <= lo_nxt;
    hip_r       <= hip_nxt;
    mid_r       <= mid_nxt;
    idx_r       <= idx_nxt;
    acc_r       <= acc_nxt;
    hit_fr_r    <= hit_fr_nxt;
    hit_off_r   <= hit_off_nxt;
    hit_final_r <= hit_final_nxt;
  end

  // per-group fill counts
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < GROUPS; k++) begin
        used_r[k] <= '0;
      end
    end else if (used_we) begin
      used_r[g_r] <= used_wd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_range_r <= '0;
      page_size_r <= 6'd32;
      eof_r       <= '0;
      cur_seg_r   <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        rrdp_pkg::CFG_MIN_RANGE:   min_range_r <= cfg_data[31:0];
        rrdp_pkg::CFG_PAGE_SIZE:   page_size_r <= cfg_data[5:0];
        rrdp_pkg::CFG_END_OF_FILE: eof_r       <= cfg_data[VW-1:0];
        rrdp_pkg::CFG_CUR_SEGMENT: cur_seg_r   <= cfg_data[6:0];
        default: ;
      endcase
    end
  end

  rrdp_ram #(.WIDTH(VW), .DEPTH(DEPTH)) u_rows (
    .clk     (clk),
    .wr_en   (we_ent),
    .wr_addr (wr_addr),
    .wr_data (item_r.first_row),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_row)
  );

  rrdp_ram #(.WIDTH(VW), .DEPTH(DEPTH)) u_offsets (
    .clk     (clk),
    .wr_en   (we_ent),
    .wr_addr (wr_addr),
    .wr_data (item_r.file_offset),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_off)
  );

  rrdp_ram #(.WIDTH(VW), .DEPTH(DEPTH)) u_counts (
    .clk     (clk),
    .wr_en   (we_cnt),
    .wr_addr (wr_addr),
    .wr_data (cnt_wd),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_cnt)
  );

  `RRDP_ASSERT_IMP(a_load_slot, load_out, slot_free, "result loaded over a pending transfer")
  `RRDP_ASSERT_IMP(a_probe_range, state_r == rrdp_pkg::ST_SRCH_RD, (lo_r < hip_r) && (hip_r <= usedc_r), "search window empty or beyond page fill")
  `RRDP_ASSERT_IMP(a_emit_idx, (state_r == rrdp_pkg::ST_EMIT_RD) || (state_r == rrdp_pkg::ST_EMIT_OUT), CW'(idx_r) < usedc_r, "emit index past page fill")
  `RRDP_ASSERT_IMP(a_fill_cap, state_r == rrdp_pkg::ST_DECODE, usedc_r <= CW'(PAGE_ENTRIES), "page fill above capacity")
  `RRDP_ASSERT_NXT(a_append_fill, (state_r == rrdp_pkg::ST_APPEND) && slot_free, used_r[g_r] != '0, "page empty after append")

endmodule

// ----- hdl/rrdp_ram.sv -----
// rrdp_ram: generic single write port, single read port ram with registered read
// no dependencies
module rrdp_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule
